FILE: hdl/cdas_pkg.sv
// Package for the Gregorian date shifter: transaction structs, status codes,
// year limits and the month length table. No dependencies.
package cdas_pkg;

    localparam int FIRST_YEAR = 1601;
    localparam int MAX_YEAR   = 9999;
    localparam int YEAR_CYCLE = 400;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_SUB = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [15:0] day_offset;
    } date_req_t;

    typedef struct packed {
        logic [4:0]  result_day;
        logic [3:0]  result_month;
        logic [13:0] result_year;
        logic [1:0]  status;
    } date_res_t;

    // Leap test from the year's remainder modulo 400.
    function automatic logic is_leap(input logic [8:0] r400);
        is_leap = (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200)
                  && (r400 != 9'd300);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        case (m)
            4'd2:    month_days = leap ? 5'd29 : 5'd28;
            4'd4:    month_days = 5'd30;
            4'd6:    month_days = 5'd30;
            4'd9:    month_days = 5'd30;
            4'd11:   month_days = 5'd30;
            default: month_days = 5'd31;
        endcase
    endfunction

endpackage

FILE: hdl/calendar_date_add_subtract_days.sv
// Gregorian date shifter top level: validates a date and moves it by a day
// offset one month per cycle.
// Depends on cdas_pkg.
//
// An invalid date is reported from the check state without stepping months.
// Throughput: one transaction at a time; busy stays high until done.
// The year's remainder modulo 400 is found by repeated subtraction first.
// done pulses for one cycle with the result; the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle.
module calendar_date_add_subtract_days (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cdas_pkg::date_req_t request,
    output logic                busy,
    output logic                done,
    output cdas_pkg::date_res_t result
);
    import cdas_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PREP  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_RUN   = 2'd3;

    logic [1:0]          state_reg,  state_next;
    date_req_t           req_reg,    req_next;
    logic [13:0]         rem_reg,    rem_next;
    logic [8:0]          r400_reg,   r400_next;
    logic [14:0]         year_reg,   year_next;
    logic [3:0]          month_reg,  month_next;
    logic signed [17:0]  day_reg,    day_next;
    logic                done_reg,   done_next;
    date_res_t           result_reg, result_next;

    logic        leap_start;
    logic [4:0]  start_len;
    logic [3:0]  month_dec;
    logic [4:0]  step_len;
    logic        step_more;
    logic        out_of_range;

    assign leap_start   = is_leap(rem_reg[8:0]);
    assign start_len    = month_days(req_reg.start_month, leap_start);
    assign month_dec    = (month_reg == 4'd1) ? 4'd12 : month_reg - 4'd1;
    assign step_len     = month_days((req_reg.kind == KIND_SUB) ? month_dec : month_reg,
                                     is_leap(r400_reg));
    assign step_more    = (req_reg.kind == KIND_SUB) ? (day_reg <= 18'sd0)
                                                     : (day_reg > $signed({13'd0, step_len}));
    assign out_of_range = (year_reg < 15'(FIRST_YEAR)) || (year_reg > 15'(MAX_YEAR));

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        rem_next    = rem_reg;
        r400_next   = r400_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    rem_next   = request.start_year;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (rem_reg >= 14'(YEAR_CYCLE))
                begin
                    rem_next = rem_reg - 14'(YEAR_CYCLE);
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((req_reg.start_year < 14'(FIRST_YEAR)) || (req_reg.start_month < 4'd1)
                    || (req_reg.start_month > 4'd12) || (req_reg.start_day < 5'd1)
                    || (req_reg.start_day > start_len))
                begin
                    result_next.result_day   = req_reg.start_day;
                    result_next.result_month = req_reg.start_month;
                    result_next.result_year  = req_reg.start_year;
                    result_next.status       = ST_BAD_DATE;
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
                else
                begin
                    r400_next  = rem_reg[8:0];
                    year_next  = {1'b0, req_reg.start_year};
                    month_next = req_reg.start_month;
                    if (req_reg.kind == KIND_SUB)
                        day_next = $signed({13'd0, req_reg.start_day})
                                   - $signed({2'd0, req_reg.day_offset});
                    else
                        day_next = $signed({13'd0, req_reg.start_day})
                                   + $signed({2'd0, req_reg.day_offset});
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (step_more)
                begin
                    if (req_reg.kind == KIND_SUB)
                    begin
                        // step back one month, then add its length
                        month_next = month_dec;
                        day_next   = day_reg + $signed({13'd0, step_len});
                        if (month_reg == 4'd1)
                        begin
                            year_next = year_reg - 15'd1;
                            r400_next = (r400_reg == 9'd0) ? 9'(YEAR_CYCLE - 1)
                                                           : r400_reg - 9'd1;
                        end
                    end
                    else
                    begin
                        // drop the current month and advance
                        day_next = day_reg - $signed({13'd0, step_len});
                        if (month_reg == 4'd12)
                        begin
                            month_next = 4'd1;
                            year_next  = year_reg + 15'd1;
                            r400_next  = (r400_reg == 9'(YEAR_CYCLE - 1)) ? 9'd0
                                                                          : r400_reg + 9'd1;
                        end
                        else
                        begin
                            month_next = month_reg + 4'd1;
                        end
                    end
                end
                else
                begin
                    if (out_of_range)
                    begin
                        result_next.result_day   = req_reg.start_day;
                        result_next.result_month = req_reg.start_month;
                        result_next.result_year  = req_reg.start_year;
                        result_next.status       = ST_RANGE;
                    end
                    else
                    begin
                        result_next.result_day   = day_reg[4:0];
                        result_next.result_month = month_reg;
                        result_next.result_year  = year_reg[13:0];
                        result_next.status       = ST_OK;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rem_reg    <= rem_next;
        r400_reg   <= r400_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while still busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_BAD_DATE
                  || result.status == ST_RANGE))
        else $error("undefined status code");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> (month_reg >= 4'd1 && month_reg <= 4'd12))
        else $error("month left 1 to 12 while stepping");

    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> (result.result_day == req_reg.start_day
            && result.result_month == req_reg.start_month
            && result.result_year == req_reg.start_year))
        else $error("failed transaction does not echo the starting date");

endmodule

FILE: tb/date_shift_checker.sv
// Checker for the Gregorian date shifter: predicts each accepted transaction's
// result date and compares it field by field with the strobed result.
// Depends on cdas_pkg.
module date_shift_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  cdas_pkg::date_req_t request,
    input  logic                done,
    input  cdas_pkg::date_res_t result,
    output int                  failures,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cdas_pkg::*;

    date_res_t expected_dates[$];
    int        fail_total = 0;
    int        queued     = 0;

    assign failures = fail_total;
    assign pending  = queued;

    function automatic bool_leap(input int y);
        bool_leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_length(input int m, input int y);
        case (m)
            2:            month_length = bool_leap(y) ? 29 : 28;
            4, 6, 9, 11:  month_length = 30;
            default:      month_length = 31;
        endcase
    endfunction

    function automatic date_res_t shift_date(input date_req_t rq);
        date_res_t r;
        int        d;
        int        m;
        int        y;
        logic [1:0] st;
        m  = int'(rq.start_month);
        y  = int'(rq.start_year);
        d  = int'(rq.start_day);
        st = ST_OK;
        if (y < FIRST_YEAR || m < 1 || m > 12 || d < 1 || d > month_length(m, y))
            st = ST_BAD_DATE;
        else if (rq.kind == KIND_ADD)
        begin
            d = d + int'(rq.day_offset);
            while (d > month_length(m, y))
            begin
                d = d - month_length(m, y);
                m++;
                if (m > 12)
                begin
                    m = 1;
                    y++;
                end
            end
        end
        else
        begin
            d = d - int'(rq.day_offset);
            while (d <= 0)
            begin
                m--;
                if (m < 1)
                begin
                    m = 12;
                    y--;
                end
                d = d + month_length(m, y);
            end
        end
        if (st == ST_OK && (y < FIRST_YEAR || y > MAX_YEAR))
            st = ST_RANGE;
        if (st != ST_OK)
        begin
            r.result_day   = rq.start_day;
            r.result_month = rq.start_month;
            r.result_year  = rq.start_year;
        end
        else
        begin
            r.result_day   = d[4:0];
            r.result_month = m[3:0];
            r.result_year  = y[13:0];
        end
        r.status = st;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        date_res_t want;
        int        errs;
        errs = 0;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_dates.size() == 0)
                begin
                    $error("result with no transaction outstanding: %p", result);
                    errs++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (result.result_day !== want.result_day)
                    begin
                        $error("result_day: expected %0d, actual %0d",
                               want.result_day, result.result_day);
                        errs++;
                    end
                    if (result.result_month !== want.result_month)
                    begin
                        $error("result_month: expected %0d, actual %0d",
                               want.result_month, result.result_month);
                        errs++;
                    end
                    if (result.result_year !== want.result_year)
                    begin
                        $error("result_year: expected %0d, actual %0d",
                               want.result_year, result.result_year);
                        errs++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, result.status);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                expected_dates.push_back(shift_date(request));
        end
        queued <= expected_dates.size();
        if (errs != 0)
            fail_total <= fail_total + errs;
    end

endmodule

FILE: tb/calendar_date_add_subtract_days_test.sv
// Top of the date shifter testbench: clock, reset, directed and random date
// transactions, and the verdict. Depends on cdas_pkg, date_shift_checker and
// calendar_date_add_subtract_days.
module calendar_date_add_subtract_days_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdas_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_ITEMS = 270;
    localparam int SETTLE_CYCLES = 2300;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    date_req_t request = '0;
    logic      busy;
    logic      done;
    date_res_t result;
    int        failures;
    int        pending;
    int        cycle_count = 0;

    always #5 clk = ~clk;

    calendar_date_add_subtract_days DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    date_shift_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .failures (failures),
        .pending  (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("calendar_date_add_subtract_days_test NOT OK");
            $finish;
        end
    end

    function automatic date_req_t make_req(input logic k, input int d, input int m,
                                           input int y, input int off);
        date_req_t rq;
        rq.kind        = k;
        rq.start_day   = d[4:0];
        rq.start_month = m[3:0];
        rq.start_year  = y[13:0];
        rq.day_offset  = off[15:0];
        return rq;
    endfunction

    function automatic date_req_t random_date();
        int pick;
        int y;
        int d;
        int off;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return make_req(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                            $urandom_range(0, 15), $urandom_range(0, 16383),
                            $urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            y = $urandom_range(FIRST_YEAR, 2500);
        else if (pick < 65)
            y = $urandom_range(FIRST_YEAR, MAX_YEAR);
        else if (pick < 80)
            y = $urandom_range(MAX_YEAR - 120, MAX_YEAR);
        else if (pick < 90)
            y = $urandom_range(FIRST_YEAR, FIRST_YEAR + 120);
        else
            y = $urandom_range(MAX_YEAR + 1, 16383);
        d = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 28) : $urandom_range(1, 31);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            off = $urandom_range(0, 1000);
        else if (pick < 85)
            off = $urandom_range(0, 20000);
        else
            off = $urandom_range(0, 65535);
        return make_req(1'($urandom_range(0, 1)), d, $urandom_range(1, 12), y, off);
    endfunction

    task automatic send(input date_req_t rq);
        request <= rq;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    date_req_t directed[$];

    initial
    begin
        directed.push_back(make_req(KIND_ADD, 15, 6, 2023, 0));
        directed.push_back(make_req(KIND_SUB, 15, 6, 2023, 0));
        directed.push_back(make_req(KIND_SUB, 1, 1, FIRST_YEAR, 1));
        directed.push_back(make_req(KIND_ADD, 31, 12, MAX_YEAR, 1));
        directed.push_back(make_req(KIND_ADD, 31, 12, MAX_YEAR, 0));
        directed.push_back(make_req(KIND_ADD, 1, 1, FIRST_YEAR, 65535));
        directed.push_back(make_req(KIND_SUB, 31, 12, MAX_YEAR, 65535));
        directed.push_back(make_req(KIND_ADD, 29, 2, 2000, 365));
        directed.push_back(make_req(KIND_ADD, 29, 2, 1900, 1));
        directed.push_back(make_req(KIND_SUB, 29, 2, 2004, 1));
        directed.push_back(make_req(KIND_ADD, 28, 2, 2100, 1));
        directed.push_back(make_req(KIND_ADD, 28, 2, 2400, 1));
        directed.push_back(make_req(KIND_SUB, 1, 3, 2400, 1));
        directed.push_back(make_req(KIND_ADD, 0, 5, 2020, 10));
        directed.push_back(make_req(KIND_ADD, 31, 4, 2020, 10));
        directed.push_back(make_req(KIND_SUB, 31, 1, 2020, 31));
        directed.push_back(make_req(KIND_ADD, 10, 0, 2020, 10));
        directed.push_back(make_req(KIND_ADD, 10, 13, 2020, 10));
        directed.push_back(make_req(KIND_SUB, 31, 15, 16383, 65535));
        directed.push_back(make_req(KIND_ADD, 10, 10, 1600, 10));
        directed.push_back(make_req(KIND_ADD, 1, 1, 0, 0));
        directed.push_back(make_req(KIND_SUB, 31, 12, 16383, 65535));
        directed.push_back(make_req(KIND_ADD, 31, 12, 16383, 0));
        directed.push_back(make_req(KIND_SUB, 30, 11, 1700, 36000));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send(directed[i]);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send(random_date());
            if (i == RANDOM_ITEMS / 2)
                drain();
            else if (i < RANDOM_ITEMS - 40 && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 14));
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("calendar_date_add_subtract_days_test OK");
        else
            $display("calendar_date_add_subtract_days_test NOT OK");
        $finish;
    end

endmodule
